/* rtl/pmsm_pkg.sv */
`default_nettype none
package pmsm_pkg;

    localparam int IN_W            = 32;
    localparam int OUT_W           = 48;
    localparam int SEL_W           = 2;
    localparam int COEF_W          = 39;
    localparam int TABLE_ROWS      = 3;
    localparam int MOTOR_COUNT_DEF = 3;

    localparam logic [SEL_W-1:0] MOTOR_0 = 2'd0;
    localparam logic [SEL_W-1:0] MOTOR_1 = 2'd1;
    localparam logic [SEL_W-1:0] MOTOR_2 = 2'd2;

    // coefficients are round-half-up of value * 2^24
    localparam longint unsigned Q25  = 64'd33554432;
    localparam longint unsigned UNIT = 64'd10000000;

    // physical values in units of 1e-7
    localparam longint unsigned M0_R  = 64'd25000000;
    localparam longint unsigned M0_LD = 64'd670000;
    localparam longint unsigned M0_LQ = 64'd670000;
    localparam longint unsigned M0_J  = 64'd500;
    localparam longint unsigned M0_P  = 64'd4;
    localparam longint unsigned M0_B  = 64'd10000000;
    localparam longint unsigned M0_L  = 64'd1700000;

    localparam longint unsigned M1_R  = 64'd26000000;
    localparam longint unsigned M1_LD = 64'd67000;
    localparam longint unsigned M1_LQ = 64'd67000;
    localparam longint unsigned M1_J  = 64'd350;
    localparam longint unsigned M1_P  = 64'd3;
    localparam longint unsigned M1_B  = 64'd500;
    localparam longint unsigned M1_L  = 64'd3190000;

    localparam longint unsigned M2_R  = 64'd43000000;
    localparam longint unsigned M2_LD = 64'd670000;
    localparam longint unsigned M2_LQ = 64'd270000;
    localparam longint unsigned M2_J  = 64'd350;
    localparam longint unsigned M2_P  = 64'd4;
    localparam longint unsigned M2_B  = 64'd500;
    localparam longint unsigned M2_L  = 64'd2720000;

    typedef struct packed {
        logic [COEF_W-1:0] kdd;
        logic [COEF_W-1:0] kdx;
        logic [COEF_W-1:0] kdv;
        logic [COEF_W-1:0] kqq;
        logic [COEF_W-1:0] kqx;
        logic [COEF_W-1:0] kqe;
        logic [COEF_W-1:0] kqv;
        logic [COEF_W-1:0] kwl;
        logic [COEF_W-1:0] kwx;
        logic [COEF_W-1:0] kwb;
        logic [COEF_W-1:0] kwt;
        logic [COEF_W-1:0] ktx;
        logic [COEF_W-1:0] ktl;
    } t_coefs;

    localparam t_coefs ROW_0 = '{
        kdd: COEF_W'((M0_R * Q25 + M0_LD) / (2 * M0_LD)),
        kdx: COEF_W'((M0_P * M0_LQ * Q25 + M0_LD) / (2 * M0_LD)),
        kdv: COEF_W'((UNIT * Q25 + M0_LD) / (2 * M0_LD)),
        kqq: COEF_W'((M0_R * Q25 + M0_LQ) / (2 * M0_LQ)),
        kqx: COEF_W'((M0_P * M0_LD * Q25 + M0_LQ) / (2 * M0_LQ)),
        kqe: COEF_W'((M0_P * M0_L * Q25 + M0_LQ) / (2 * M0_LQ)),
        kqv: COEF_W'((UNIT * Q25 + M0_LQ) / (2 * M0_LQ)),
        kwl: COEF_W'((M0_P * M0_L * Q25 + M0_J) / (2 * M0_J)),
        kwx: COEF_W'((M0_P * (M0_LD - M0_LQ) * Q25 + M0_J) / (2 * M0_J)),
        kwb: COEF_W'((M0_B * Q25 + M0_J) / (2 * M0_J)),
        kwt: COEF_W'((UNIT * Q25 + M0_J) / (2 * M0_J)),
        ktx: COEF_W'((3 * M0_P * (M0_LD - M0_LQ) * Q25 + 4 * UNIT) / (8 * UNIT)),
        ktl: COEF_W'((3 * M0_P * M0_L * Q25 + 4 * UNIT) / (8 * UNIT))
    };

    localparam t_coefs ROW_1 = '{
        kdd: COEF_W'((M1_R * Q25 + M1_LD) / (2 * M1_LD)),
        kdx: COEF_W'((M1_P * M1_LQ * Q25 + M1_LD) / (2 * M1_LD)),
        kdv: COEF_W'((UNIT * Q25 + M1_LD) / (2 * M1_LD)),
        kqq: COEF_W'((M1_R * Q25 + M1_LQ) / (2 * M1_LQ)),
        kqx: COEF_W'((M1_P * M1_LD * Q25 + M1_LQ) / (2 * M1_LQ)),
        kqe: COEF_W'((M1_P * M1_L * Q25 + M1_LQ) / (2 * M1_LQ)),
        kqv: COEF_W'((UNIT * Q25 + M1_LQ) / (2 * M1_LQ)),
        kwl: COEF_W'((M1_P * M1_L * Q25 + M1_J) / (2 * M1_J)),
        kwx: COEF_W'((M1_P * (M1_LD - M1_LQ) * Q25 + M1_J) / (2 * M1_J)),
        kwb: COEF_W'((M1_B * Q25 + M1_J) / (2 * M1_J)),
        kwt: COEF_W'((UNIT * Q25 + M1_J) / (2 * M1_J)),
        ktx: COEF_W'((3 * M1_P * (M1_LD - M1_LQ) * Q25 + 4 * UNIT) / (8 * UNIT)),
        ktl: COEF_W'((3 * M1_P * M1_L * Q25 + 4 * UNIT) / (8 * UNIT))
    };

    localparam t_coefs ROW_2 = '{
        kdd: COEF_W'((M2_R * Q25 + M2_LD) / (2 * M2_LD)),
        kdx: COEF_W'((M2_P * M2_LQ * Q25 + M2_LD) / (2 * M2_LD)),
        kdv: COEF_W'((UNIT * Q25 + M2_LD) / (2 * M2_LD)),
        kqq: COEF_W'((M2_R * Q25 + M2_LQ) / (2 * M2_LQ)),
        kqx: COEF_W'((M2_P * M2_LD * Q25 + M2_LQ) / (2 * M2_LQ)),
        kqe: COEF_W'((M2_P * M2_L * Q25 + M2_LQ) / (2 * M2_LQ)),
        kqv: COEF_W'((UNIT * Q25 + M2_LQ) / (2 * M2_LQ)),
        kwl: COEF_W'((M2_P * M2_L * Q25 + M2_J) / (2 * M2_J)),
        kwx: COEF_W'((M2_P * (M2_LD - M2_LQ) * Q25 + M2_J) / (2 * M2_J)),
        kwb: COEF_W'((M2_B * Q25 + M2_J) / (2 * M2_J)),
        kwt: COEF_W'((UNIT * Q25 + M2_J) / (2 * M2_J)),
        ktx: COEF_W'((3 * M2_P * (M2_LD - M2_LQ) * Q25 + 4 * UNIT) / (8 * UNIT)),
        ktl: COEF_W'((3 * M2_P * M2_L * Q25 + 4 * UNIT) / (8 * UNIT))
    };

    function automatic t_coefs motor_coefs(input logic [SEL_W-1:0] sel);
        t_coefs row;
        case (sel)
            MOTOR_0: row = ROW_0;
            MOTOR_1: row = ROW_1;
            MOTOR_2: row = ROW_2;
            default: row = ROW_0;
        endcase
        return row;
    endfunction

endpackage
`default_nettype wire

/* rtl/pmsm_dq_derivative_eval.sv */
// channel   | handshake                   | payload
// ----------+-----------------------------+-------------------------------------------
// input     | start, busy                 | i_current_d/q, i_rotor_speed, i_volt_d/q,
//           |                             | i_load_torque (signed Q16.16)
// config    | i_cfg_valid, o_cfg_ready    | i_cfg_data (motor select)
// result    | o_strobe (one cycle)        | o_d_current_d/q, o_d_speed, o_d_angle,
//           |                             | o_torque_out (signed Q32.16)
//
// one transaction per cycle; each result passes stages a to e and the output stage before it is taken
// depth set by the coefficient multipliers, split into 24-bit and 15-bit halves
// synchronous active-low reset clears the pipeline and selects motor 0; busy stays
// high and cfg ready low during reset and in the cycle after reset ends
// nothing stalls: busy is never raised by traffic, results cannot be held off
`default_nettype none
module pmsm_dq_derivative_eval #(
    parameter int MOTOR_COUNT = pmsm_pkg::MOTOR_COUNT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_current_d,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_current_q,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_rotor_speed,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_volt_d,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_volt_q,
    input  wire signed [pmsm_pkg::IN_W-1:0]     i_load_torque,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire        [pmsm_pkg::SEL_W-1:0]    i_cfg_data,
    output logic                                o_strobe,
    output logic signed [pmsm_pkg::OUT_W-1:0]   o_d_current_d,
    output logic signed [pmsm_pkg::OUT_W-1:0]   o_d_current_q,
    output logic signed [pmsm_pkg::OUT_W-1:0]   o_d_speed,
    output logic signed [pmsm_pkg::OUT_W-1:0]   o_d_angle,
    output logic signed [pmsm_pkg::OUT_W-1:0]   o_torque_out
);
    import pmsm_pkg::*;

    localparam int SEL_LIMIT  = (MOTOR_COUNT < TABLE_ROWS) ? MOTOR_COUNT : TABLE_ROWS;
    localparam int CLO_W      = 24;
    localparam int CHI_W      = COEF_W - CLO_W;
    localparam int PROD_W     = 2 * IN_W;
    localparam int ACC_W      = COEF_W + PROD_W + 1;
    localparam int IN_ALIGN   = 16;
    localparam int FRAC_SHIFT = 40;
    localparam int SAT_LO     = FRAC_SHIFT + OUT_W - 1;

    localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // terms with one input operand
    localparam int T_DD = 0;
    localparam int T_DV = 1;
    localparam int T_QQ = 2;
    localparam int T_QE = 3;
    localparam int T_QV = 4;
    localparam int T_WL = 5;
    localparam int T_WB = 6;
    localparam int T_WT = 7;
    localparam int T_TL = 8;
    localparam int N_IT = 9;
    // terms with a product of two inputs
    localparam int P_DX = 0;
    localparam int P_QX = 1;
    localparam int P_WX = 2;
    localparam int P_TX = 3;
    localparam int N_PT = 4;
    // outputs that need rounding
    localparam int O_D  = 0;
    localparam int O_Q  = 1;
    localparam int O_W  = 2;
    localparam int O_T  = 3;
    localparam int N_O  = 4;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-SAT_LO-1:0] hi_bits;
        hi_bits = acc[ACC_W-1:SAT_LO];
        if (hi_bits == {(ACC_W-SAT_LO){acc[ACC_W-1]}}) begin
            return acc[SAT_LO:FRAC_SHIFT];
        end else if (acc[ACC_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

    // control
    logic             r_busy;
    logic [SEL_W-1:0] r_motor_select;
    logic             r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_out_valid;

    // stage a: registered inputs and coefficient row
    logic signed [IN_W-1:0] r_a_id, r_a_iq, r_a_wr, r_a_vd, r_a_vq, r_a_tl;
    t_coefs                 r_a_coef;

    // stage b: operand pairs, two-input products done
    logic        [COEF_W-1:0] n_b_ic [N_IT];
    logic signed [IN_W-1:0]   n_b_ix [N_IT];
    logic        [COEF_W-1:0] n_b_pc [N_PT];
    logic signed [PROD_W-1:0] n_b_px [N_PT];
    logic signed [PROD_W-1:0] n_idiq, n_wriq, n_wrid;
    logic        [COEF_W-1:0] r_b_ic [N_IT];
    logic signed [IN_W-1:0]   r_b_ix [N_IT];
    logic        [COEF_W-1:0] r_b_pc [N_PT];
    logic signed [PROD_W-1:0] r_b_px [N_PT];
    logic signed [IN_W-1:0]   r_b_wr;

    // stage c: partial products
    logic signed [CLO_W+IN_W:0]   n_c_il  [N_IT];
    logic signed [CHI_W+IN_W:0]   n_c_ih  [N_IT];
    logic signed [CLO_W+IN_W+1:0] n_c_pll [N_PT];
    logic signed [CLO_W+IN_W:0]   n_c_plh [N_PT];
    logic signed [CHI_W+IN_W+1:0] n_c_phl [N_PT];
    logic signed [CHI_W+IN_W:0]   n_c_phh [N_PT];
    logic signed [CLO_W+IN_W:0]   r_c_il  [N_IT];
    logic signed [CHI_W+IN_W:0]   r_c_ih  [N_IT];
    logic signed [CLO_W+IN_W+1:0] r_c_pll [N_PT];
    logic signed [CLO_W+IN_W:0]   r_c_plh [N_PT];
    logic signed [CHI_W+IN_W+1:0] r_c_phl [N_PT];
    logic signed [CHI_W+IN_W:0]   r_c_phh [N_PT];
    logic signed [IN_W-1:0]       r_c_wr;

    // stage d: full terms at 56 fraction bits
    logic signed [ACC_W-1:0] n_d_it [N_IT];
    logic signed [ACC_W-1:0] n_d_pt [N_PT];
    logic signed [ACC_W-1:0] r_d_it [N_IT];
    logic signed [ACC_W-1:0] r_d_pt [N_PT];
    logic signed [IN_W-1:0]  r_d_wr;

    // stage e: sums with rounding constant
    logic signed [ACC_W-1:0] n_e_acc [N_O];
    logic signed [ACC_W-1:0] r_e_acc [N_O];
    logic signed [IN_W-1:0]  r_e_wr;

    // output stage
    logic signed [OUT_W-1:0] r_out [N_O];
    logic signed [OUT_W-1:0] r_out_angle;

    assign busy          = r_busy;
    assign o_cfg_ready   = !r_busy;
    assign o_strobe      = r_out_valid;
    assign o_d_current_d = r_out[O_D];
    assign o_d_current_q = r_out[O_Q];
    assign o_d_speed     = r_out[O_W];
    assign o_torque_out  = r_out[O_T];
    assign o_d_angle     = r_out_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b1;
            r_motor_select <= MOTOR_0;
            r_a_valid      <= 1'b0;
            r_b_valid      <= 1'b0;
            r_c_valid      <= 1'b0;
            r_d_valid      <= 1'b0;
            r_e_valid      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            // selections beyond the table or beyond MOTOR_COUNT are dropped
            if (i_cfg_valid && o_cfg_ready && (int'(i_cfg_data) < SEL_LIMIT)) begin
                r_motor_select <= i_cfg_data;
            end
            r_a_valid   <= start && !r_busy;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    always_comb begin
        n_idiq = r_a_id * r_a_iq;
        n_wriq = r_a_wr * r_a_iq;
        n_wrid = r_a_wr * r_a_id;

        n_b_ic[T_DD] = r_a_coef.kdd;  n_b_ix[T_DD] = r_a_id;
        n_b_ic[T_DV] = r_a_coef.kdv;  n_b_ix[T_DV] = r_a_vd;
        n_b_ic[T_QQ] = r_a_coef.kqq;  n_b_ix[T_QQ] = r_a_iq;
        n_b_ic[T_QE] = r_a_coef.kqe;  n_b_ix[T_QE] = r_a_wr;
        n_b_ic[T_QV] = r_a_coef.kqv;  n_b_ix[T_QV] = r_a_vq;
        n_b_ic[T_WL] = r_a_coef.kwl;  n_b_ix[T_WL] = r_a_iq;
        n_b_ic[T_WB] = r_a_coef.kwb;  n_b_ix[T_WB] = r_a_wr;
        n_b_ic[T_WT] = r_a_coef.kwt;  n_b_ix[T_WT] = r_a_tl;
        n_b_ic[T_TL] = r_a_coef.ktl;  n_b_ix[T_TL] = r_a_iq;

        n_b_pc[P_DX] = r_a_coef.kdx;  n_b_px[P_DX] = n_wriq;
        n_b_pc[P_QX] = r_a_coef.kqx;  n_b_px[P_QX] = n_wrid;
        n_b_pc[P_WX] = r_a_coef.kwx;  n_b_px[P_WX] = n_idiq;
        n_b_pc[P_TX] = r_a_coef.ktx;  n_b_px[P_TX] = n_idiq;
    end

    // coefficient split as hi * 2^24 + lo, wide operand as hi * 2^32 + lo
    always_comb begin
        for (int k = 0; k < N_IT; k++) begin
            n_c_il[k] = $signed({1'b0, r_b_ic[k][CLO_W-1:0]}) * r_b_ix[k];
            n_c_ih[k] = $signed({1'b0, r_b_ic[k][COEF_W-1:CLO_W]}) * r_b_ix[k];
        end
        for (int k = 0; k < N_PT; k++) begin
            n_c_pll[k] = $signed({1'b0, r_b_pc[k][CLO_W-1:0]})
                       * $signed({1'b0, r_b_px[k][IN_W-1:0]});
            n_c_plh[k] = $signed({1'b0, r_b_pc[k][CLO_W-1:0]})
                       * $signed(r_b_px[k][PROD_W-1:IN_W]);
            n_c_phl[k] = $signed({1'b0, r_b_pc[k][COEF_W-1:CLO_W]})
                       * $signed({1'b0, r_b_px[k][IN_W-1:0]});
            n_c_phh[k] = $signed({1'b0, r_b_pc[k][COEF_W-1:CLO_W]})
                       * $signed(r_b_px[k][PROD_W-1:IN_W]);
        end
    end

    always_comb begin
        for (int k = 0; k < N_IT; k++) begin
            // single inputs enter as Q32.32
            n_d_it[k] = (ACC_W'(r_c_ih[k]) <<< (CLO_W + IN_ALIGN))
                      + (ACC_W'(r_c_il[k]) <<< IN_ALIGN);
        end
        for (int k = 0; k < N_PT; k++) begin
            n_d_pt[k] = (ACC_W'(r_c_phh[k]) <<< (CLO_W + IN_W))
                      + (ACC_W'(r_c_plh[k]) <<< IN_W)
                      + (ACC_W'(r_c_phl[k]) <<< CLO_W)
                      + ACC_W'(r_c_pll[k]);
        end
    end

    always_comb begin
        n_e_acc[O_D] = r_d_pt[P_DX] + r_d_it[T_DV] - r_d_it[T_DD] + ROUND;
        n_e_acc[O_Q] = r_d_it[T_QV] - r_d_it[T_QQ] - r_d_pt[P_QX] - r_d_it[T_QE] + ROUND;
        n_e_acc[O_W] = r_d_it[T_WL] + r_d_pt[P_WX] - r_d_it[T_WB] - r_d_it[T_WT] + ROUND;
        n_e_acc[O_T] = r_d_pt[P_TX] + r_d_it[T_TL] + ROUND;
    end

    always_ff @(posedge i_clk) begin
        r_a_id   <= i_current_d;
        r_a_iq   <= i_current_q;
        r_a_wr   <= i_rotor_speed;
        r_a_vd   <= i_volt_d;
        r_a_vq   <= i_volt_q;
        r_a_tl   <= i_load_torque;
        r_a_coef <= motor_coefs(r_motor_select);

        r_b_ic <= n_b_ic;
        r_b_ix <= n_b_ix;
        r_b_pc <= n_b_pc;
        r_b_px <= n_b_px;
        r_b_wr <= r_a_wr;

        r_c_il  <= n_c_il;
        r_c_ih  <= n_c_ih;
        r_c_pll <= n_c_pll;
        r_c_plh <= n_c_plh;
        r_c_phl <= n_c_phl;
        r_c_phh <= n_c_phh;
        r_c_wr  <= r_b_wr;

        r_d_it <= n_d_it;
        r_d_pt <= n_d_pt;
        r_d_wr <= r_c_wr;

        r_e_acc <= n_e_acc;
        r_e_wr  <= r_d_wr;

        for (int k = 0; k < N_O; k++) begin
            r_out[k] <= round_sat(r_e_acc[k]);
        end
        r_out_angle <= OUT_W'(r_e_wr);
    end

endmodule
`default_nettype wire

/* rtl/pmsm_checker.sv */
`default_nettype none
module pmsm_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                start,
    input wire                                busy,
    input wire signed [pmsm_pkg::IN_W-1:0]    i_rotor_speed,
    input wire                                o_cfg_ready,
    input wire                                o_strobe,
    input wire signed [pmsm_pkg::OUT_W-1:0]   o_d_angle
);
    import pmsm_pkg::*;

    localparam int LAT = 6;

    // every transaction comes back as a result strobe, angle rate is the speed
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT (o_strobe
            && (o_d_angle[IN_W-1:0] == $past(i_rotor_speed, LAT))
            && (o_d_angle[OUT_W-1:IN_W] == {(OUT_W-IN_W){o_d_angle[IN_W-1]}})))
        else $error("result missing or wrong angle rate after start");

    // no result without a transaction that caused it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result strobe without matching start");

    // reset flushes the pipeline and blocks both input channels
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && busy && !o_cfg_ready))
        else $error("pipeline not flushed by reset");

endmodule

bind pmsm_dq_derivative_eval pmsm_checker u_pmsm_checker (.*);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import pmsm_pkg::*;

    localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 80;
    localparam int DIR_N = 23;
    localparam int DRAIN_CYCLES = 12;

    // phase 0 in the low bits; the unused code must leave the selection alone
    localparam logic [2*NUM_PHASES-1:0] PHASE_SEL = {MOTOR_0, SEL_UNUSED, MOTOR_1, MOTOR_2,
                                                     MOTOR_0, SEL_UNUSED, MOTOR_2, MOTOR_1};

    localparam longint unsigned SCALE_1E7 = 64'd10000000;
    localparam longint unsigned Q24_X2 = 64'd33554432;

    localparam logic signed [31:0] IMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] IMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] NEG1 = 32'shFFFF_FFFF;
    localparam logic signed [31:0] ZI = 32'sh0;
    localparam logic [47:0] SMAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SMIN = 48'h8000_0000_0000;
    localparam logic [47:0] Z48 = 48'h0;
    localparam logic [47:0] ANG_MAX = 48'h0000_7FFF_FFFF;
    localparam logic [47:0] ANG_MIN = 48'hFFFF_8000_0000;
    localparam logic [47:0] ANG_NEG1 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] id, iq, wr, vd, vq, tl;
    } t_sample;

    typedef struct packed {
        logic [47:0] dcd, dcq, dspd, dang, trq;
    } t_deriv;

    // fixed expectation bits: dcd, dcq, dspd, dang, trq from msb down
    typedef struct packed {
        logic signed [31:0] id, iq, wr, vd, vq, tl;
        logic [4:0]         fixed;
        logic [47:0]        dcd, dcq, dspd, dang, trq;
    } t_row;

    typedef struct {
        longint kdd, kdx, kdv, kqq, kqx, kqe, kqv, kwl, kwx, kwb, kwt, ktx, ktl;
    } t_gain;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_current_d = '0;
    logic signed [31:0] i_current_q = '0;
    logic signed [31:0] i_rotor_speed = '0;
    logic signed [31:0] i_volt_d = '0;
    logic signed [31:0] i_volt_q = '0;
    logic signed [31:0] i_load_torque = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SEL_W-1:0]   i_cfg_data = '0;
    logic               o_strobe;
    logic signed [47:0] o_d_current_d;
    logic signed [47:0] o_d_current_q;
    logic signed [47:0] o_d_speed;
    logic signed [47:0] o_d_angle;
    logic signed [47:0] o_torque_out;

    logic [SEL_W-1:0] motor_sel = MOTOR_0;
    t_deriv           pending_derivs[$];
    int               mismatch_cnt = 0;
    t_row             dir_rows [DIR_N];

    pmsm_dq_derivative_eval dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_current_d   (i_current_d),
        .i_current_q   (i_current_q),
        .i_rotor_speed (i_rotor_speed),
        .i_volt_d      (i_volt_d),
        .i_volt_q      (i_volt_q),
        .i_load_torque (i_load_torque),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_d_current_d (o_d_current_d),
        .o_d_current_q (o_d_current_q),
        .o_d_speed     (o_d_speed),
        .o_d_angle     (o_d_angle),
        .o_torque_out  (o_torque_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // q40.24 gain, round half up of n / d
    function automatic longint gain_q24(input longint unsigned n, input longint unsigned d);
        return longint'((n * Q24_X2 + d) / (2 * d));
    endfunction

    function automatic t_gain motor_gains(input logic [SEL_W-1:0] sel);
        longint unsigned r, ld, lq, j, p, b, l;
        t_gain g;
        // physical values scaled by 1e7
        case (sel)
            MOTOR_1: begin
                r = 26000000; ld = 67000;  lq = 67000;  j = 350; p = 3; b = 500; l = 3190000;
            end
            MOTOR_2: begin
                r = 43000000; ld = 670000; lq = 270000; j = 350; p = 4; b = 500; l = 2720000;
            end
            default: begin
                r = 25000000; ld = 670000; lq = 670000; j = 500; p = 4; b = 10000000;
                l = 1700000;
            end
        endcase
        g.kdd = gain_q24(r, ld);
        g.kdx = gain_q24(p * lq, ld);
        g.kdv = gain_q24(SCALE_1E7, ld);
        g.kqq = gain_q24(r, lq);
        g.kqx = gain_q24(p * ld, lq);
        g.kqe = gain_q24(p * l, lq);
        g.kqv = gain_q24(SCALE_1E7, lq);
        g.kwl = gain_q24(p * l, j);
        g.kwx = gain_q24(p * (ld - lq), j);
        g.kwb = gain_q24(b, j);
        g.kwt = gain_q24(SCALE_1E7, j);
        g.ktx = gain_q24(3 * p * (ld - lq), 4 * SCALE_1E7);
        g.ktl = gain_q24(3 * p * l, 4 * SCALE_1E7);
        return g;
    endfunction

    function automatic logic signed [127:0] wide_mul(input longint c, input longint x);
        logic signed [127:0] a, b;
        a = c;
        b = x;
        return a * b;
    endfunction

    // sum is at 56 fraction bits; round half up to 16 and clamp to 48 bits
    function automatic logic [47:0] round_sat(input logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + 128'sh80_0000_0000) >>> 40;
        if (r > 128'sh7FFF_FFFF_FFFF)
            return SMAX;
        else if (r < -128'sh8000_0000_0000)
            return SMIN;
        return r[47:0];
    endfunction

    function automatic t_deriv eval_pmsm_derivs(input logic [SEL_W-1:0] sel,
                                                input logic signed [31:0] id, iq, wr,
                                                input logic signed [31:0] vd, vq, tl);
        t_gain  g;
        longint sid, siq, swr, svd, svq, stl;
        t_deriv res;
        g = motor_gains(sel);
        sid = id;
        siq = iq;
        swr = wr;
        svd = vd;
        svq = vq;
        stl = tl;
        // single inputs are lifted to q32.32 to line up with the products
        res.dcd = round_sat(-wide_mul(g.kdd, sid <<< 16) + wide_mul(g.kdx, swr * siq)
                            + wide_mul(g.kdv, svd <<< 16));
        res.dcq = round_sat(-wide_mul(g.kqq, siq <<< 16) - wide_mul(g.kqx, swr * sid)
                            - wide_mul(g.kqe, swr <<< 16) + wide_mul(g.kqv, svq <<< 16));
        res.dspd = round_sat(wide_mul(g.kwl, siq <<< 16) + wide_mul(g.kwx, sid * siq)
                             - wide_mul(g.kwb, swr <<< 16) - wide_mul(g.kwt, stl <<< 16));
        res.dang = {{16{wr[31]}}, wr};
        res.trq = round_sat(wide_mul(g.ktx, sid * siq) + wide_mul(g.ktl, siq <<< 16));
        return res;
    endfunction

    function automatic logic signed [31:0] rand_field();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return $urandom;
        else if (pick < 85)
            return $signed($urandom) >>> $urandom_range(31);
        case ($urandom_range(5))
            0: return IMAX;
            1: return IMIN;
            2: return NEG1;
            3: return ONE;
            4: return -ONE;
            default: return ZI;
        endcase
    endfunction

    task automatic check_field(input string tag, input logic [47:0] got, input logic [47:0] want);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch %s: expected %h got %h", tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_deriv want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_derivs.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transaction: strobe %b", o_strobe);
            end else begin
                want = pending_derivs.pop_front();
                check_field("d_current_d", o_d_current_d, want.dcd);
                check_field("d_current_q", o_d_current_q, want.dcq);
                check_field("d_speed", o_d_speed, want.dspd);
                check_field("d_angle", o_d_angle, want.dang);
                check_field("torque_out", o_torque_out, want.trq);
            end
        end
    end

    task automatic send_item(input t_sample s, input logic [4:0] fixed, input t_deriv fixed_vals,
                             input int idle_pct);
        t_deriv want;
        start <= 1'b1;
        i_current_d <= s.id;
        i_current_q <= s.iq;
        i_rotor_speed <= s.wr;
        i_volt_d <= s.vd;
        i_volt_q <= s.vq;
        i_load_torque <= s.tl;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = eval_pmsm_derivs(motor_sel, s.id, s.iq, s.wr, s.vd, s.vq, s.tl);
        if (fixed[4]) want.dcd = fixed_vals.dcd;
        if (fixed[3]) want.dcq = fixed_vals.dcq;
        if (fixed[2]) want.dspd = fixed_vals.dspd;
        if (fixed[1]) want.dang = fixed_vals.dang;
        if (fixed[0]) want.trq = fixed_vals.trq;
        pending_derivs.push_back(want);
        // each further cycle is idle with the given odds
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_derivs.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_select(input logic [SEL_W-1:0] sel);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= sel;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        if (sel < MOTOR_COUNT_DEF && sel < TABLE_ROWS)
            motor_sel = sel;
    endtask

    initial begin
        t_sample s;
        t_deriv  fv;
        int      idle_pct;

        // saturating rows: the cross products dominate with gain 4 on motor 0
        dir_rows[0]  = '{ZI, ZI, ZI, ZI, ZI, ZI, 5'b11111, Z48, Z48, Z48, Z48, Z48};
        dir_rows[1]  = '{IMAX, IMAX, IMAX, ZI, ZI, ZI, 5'b11010, SMAX, SMIN, Z48, ANG_MAX, Z48};
        dir_rows[2]  = '{IMIN, IMAX, IMAX, ZI, ZI, ZI, 5'b11010, SMAX, SMAX, Z48, ANG_MAX, Z48};
        dir_rows[3]  = '{IMAX, IMIN, IMIN, ZI, ZI, ZI, 5'b11010, SMAX, SMAX, Z48, ANG_MIN, Z48};
        dir_rows[4]  = '{IMIN, IMIN, IMAX, ZI, ZI, ZI, 5'b11010, SMIN, SMAX, Z48, ANG_MAX, Z48};
        dir_rows[5]  = '{ZI, ZI, IMIN, ZI, ZI, ZI, 5'b00010, Z48, Z48, Z48, ANG_MIN, Z48};
        dir_rows[6]  = '{ZI, ZI, NEG1, ZI, ZI, ZI, 5'b00010, Z48, Z48, Z48, ANG_NEG1, Z48};
        dir_rows[7]  = '{ZI, ZI, ZI, IMAX, ZI, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[8]  = '{ZI, ZI, ZI, IMIN, ZI, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[9]  = '{ZI, ZI, ZI, ZI, IMAX, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[10] = '{ZI, ZI, ZI, ZI, IMIN, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[11] = '{ZI, ZI, ZI, ZI, ZI, IMAX, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[12] = '{ZI, ZI, ZI, ZI, ZI, IMIN, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[13] = '{IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, 5'b00010,
                         Z48, Z48, Z48, ANG_MAX, Z48};
        dir_rows[14] = '{IMIN, IMIN, IMIN, IMIN, IMIN, IMIN, 5'b00010,
                         Z48, Z48, Z48, ANG_MIN, Z48};
        dir_rows[15] = '{32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555, 32'sh5555_5555,
                         32'sh5555_5555, 32'sh5555_5555, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[16] = '{32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'shAAAA_AAAA,
                         32'shAAAA_AAAA, 32'shAAAA_AAAA, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[17] = '{ONE, ONE, ONE, ONE, ONE, ONE, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[18] = '{NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, 5'b00000,
                         Z48, Z48, Z48, ANG_NEG1, Z48};
        dir_rows[19] = '{32'sh0002_8000, -ONE, 32'sh0064_0000, 32'sh000C_0000, 32'shFFF4_0000,
                         32'sh0000_4000, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[20] = '{32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh1, 5'b00000,
                         Z48, Z48, Z48, Z48, Z48};
        dir_rows[21] = '{ZI, IMAX, ZI, ZI, ZI, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};
        dir_rows[22] = '{IMIN, IMIN, ZI, ZI, ZI, ZI, 5'b00000, Z48, Z48, Z48, Z48, Z48};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows run on the reset selection, back to back
        for (int k = 0; k < DIR_N; k++) begin
            s = '{dir_rows[k].id, dir_rows[k].iq, dir_rows[k].wr,
                  dir_rows[k].vd, dir_rows[k].vq, dir_rows[k].tl};
            fv = '{dir_rows[k].dcd, dir_rows[k].dcq, dir_rows[k].dspd,
                   dir_rows[k].dang, dir_rows[k].trq};
            send_item(s, dir_rows[k].fixed, fv, 0);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_select(PHASE_SEL[2*ph +: 2]);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 66;
                default: idle_pct = 31;
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                s = '{rand_field(), rand_field(), rand_field(),
                      rand_field(), rand_field(), rand_field()};
                send_item(s, 5'b00000, '0, idle_pct);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
